>>> rtl/hbsd_pkg.sv
package hbsd_pkg;

  // field widths of the beats
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned CODE_BITS_W = 32;
  localparam int unsigned CODE_LEN_W = 6;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PENDING_W  = 6;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PATH   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // pending bit counter saturates here
  localparam logic [PENDING_W-1:0] PENDING_MAX = 6'd63;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]       symbol_in;
    logic                   data_bit;
  } in_beat_t;

  typedef struct packed {
    logic                 symbol_valid;
    logic [SYM_W-1:0]     symbol_out;
    logic [STATUS_W-1:0]  status;
    logic [PENDING_W-1:0] pending_bits;
  } out_beat_t;

endpackage

>>> rtl/huffman_bit_serial_decoder_core.sv
// Huffman tree decoder on a node table held in one synchronous RAM (left child,
// right child, leaf flag and symbol per node; node 0 is the root). Each input
// beat is an insert, a one-bit decode step or a table clear, and gives exactly
// one result beat. Items are handled one at a time: a decode step reads the
// current node and then, unless the child is missing, the child; an insert
// walks one node per bit of its effective code length, then marks the leaf or
// reports a duplicate (stopping early when the table runs full on the way); a
// clear or an unused opcode needs no table read. The dependent node reads go
// through the single registered RAM read port. No clearing pass runs after
// reset or a clear: a fill count marks the allocated nodes and the root has a
// valid bit, so the block takes beats right after reset. A two-entry output
// stage lets a result wait on a stalled output while the next item is taken.
module huffman_bit_serial_decoder_core #(
  parameter int unsigned NODE_COUNT      = 512,
  parameter int unsigned MAX_CODE_LENGTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hbsd_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hbsd_pkg::out_beat_t out_beat_o
);

  import hbsd_pkg::*;

  localparam int unsigned NW    = $clog2(NODE_COUNT);
  localparam int unsigned NodeW = 2 * NW + SYM_W + 1;

  logic             start;
  logic             busy;
  logic             res_valid;
  out_beat_t        res;
  logic             mem_we;
  logic [NW-1:0]    mem_waddr;
  logic [NodeW-1:0] mem_wdata;
  logic [NW-1:0]    mem_raddr;
  logic [NodeW-1:0] mem_rdata;

  out_beat_t        out_q;
  logic             out_valid_q;
  out_beat_t        hold_q;
  logic             hold_valid_q;
  logic             out_free;

  assign in_stall_o = busy | hold_valid_q;
  assign start      = in_valid_i & ~in_stall_o;

  hbsd_walker #(
    .NODE_COUNT      (NODE_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .NW              (NW),
    .NodeW           (NodeW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .beat_i      (in_beat_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  hbsd_node_mem #(
    .Depth (NODE_COUNT),
    .DataW (NodeW),
    .AddrW (NW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign out_free = ~out_valid_q | ~out_stall_i;

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (hold_valid_q) begin
          out_valid_q  <= 1'b1;
          hold_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        hold_valid_q <= 1'b1;
      end
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (hold_valid_q) begin
        out_q <= hold_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      hold_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

>>> rtl/hbsd_node_mem.sv
module hbsd_node_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned DataW = 27,
  parameter int unsigned AddrW = 9
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/hbsd_walker.sv
module hbsd_walker #(
  parameter int unsigned NODE_COUNT      = 512,
  parameter int unsigned MAX_CODE_LENGTH = 32,
  parameter int unsigned NW              = 9,
  parameter int unsigned NodeW           = 27
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hbsd_pkg::in_beat_t  beat_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output hbsd_pkg::out_beat_t res_o,
  output logic                mem_we_o,
  output logic [NW-1:0]       mem_waddr_o,
  output logic [NodeW-1:0]    mem_wdata_o,
  output logic [NW-1:0]       mem_raddr_o,
  input  logic [NodeW-1:0]    mem_rdata_i
);

  import hbsd_pkg::*;

  localparam int unsigned LW = $clog2(MAX_CODE_LENGTH + 1);
  localparam int unsigned CW = (LW > CODE_LEN_W) ? LW : CODE_LEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_DCH  = 2'd2;
  localparam logic [1:0] S_DLF  = 2'd3;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [NW-1:0]    right;
    logic [NW-1:0]    left;
  } node_t;

  logic [1:0]             state_q, state_d;
  logic [NW:0]            next_free_q, next_free_d;
  logic [NW-1:0]          cur_q, cur_d;
  logic [PENDING_W-1:0]   pend_q, pend_d;
  logic                   root_valid_q, root_valid_d;
  logic [NW-1:0]          rd_addr_q;
  logic [NW-1:0]          node_q, node_d;
  logic                   fresh_q, fresh_d;
  logic [LW-1:0]          rem_q, rem_d;
  logic [CODE_BITS_W-1:0] bits_q, bits_d;
  logic [SYM_W-1:0]       sym_q, sym_d;
  logic                   bit_q, bit_d;
  logic [NW-1:0]          child_q, child_d;

  node_t                  word;
  node_t                  cur_word;
  node_t                  wr_word;
  logic [NW-1:0]          raddr;
  logic [NW-1:0]          slot;
  logic [NW-1:0]          child;
  logic [LW-1:0]          pos;
  logic [CODE_BITS_W-1:0] shifted;
  logic                   walk_bit;
  logic [CW-1:0]          len_ext;
  logic [LW-1:0]          eff_len;
  logic                   table_full;

  // root reads as empty until first written after reset or clear
  assign word = ((rd_addr_q == '0) && !root_valid_q) ? '0 : node_t'(mem_rdata_i);
  // a node allocated during this walk is known empty and is not read back
  assign cur_word = fresh_q ? '0 : word;

  // current code bit, positions above the code word read as zero
  assign pos      = rem_q - 1'b1;
  assign shifted  = bits_q >> pos;
  assign walk_bit = shifted[0];
  assign slot     = walk_bit ? cur_word.right : cur_word.left;
  assign child    = bit_q ? word.right : word.left;

  // effective code length clamps at the longest supported code
  assign len_ext = CW'(beat_i.code_length);
  assign eff_len = (len_ext > CW'(MAX_CODE_LENGTH)) ? LW'(MAX_CODE_LENGTH)
                                                    : LW'(beat_i.code_length);

  assign table_full = (next_free_q == (NW + 1)'(NODE_COUNT));

  // walk control
  always_comb begin
    state_d      = state_q;
    next_free_d  = next_free_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    root_valid_d = root_valid_q;
    node_d       = node_q;
    fresh_d      = fresh_q;
    rem_d        = rem_q;
    bits_d       = bits_q;
    sym_d        = sym_q;
    bit_d        = bit_q;
    child_d      = child_q;
    raddr        = rd_addr_q;
    mem_we_o     = 1'b0;
    wr_word      = cur_word;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (beat_i.opcode)
            OP_INSERT: begin
              rem_d   = eff_len;
              bits_d  = beat_i.code_bits;
              sym_d   = beat_i.symbol_in;
              node_d  = '0;
              fresh_d = 1'b0;
              raddr   = '0;
              state_d = S_INS;
            end
            OP_DECODE: begin
              bit_d   = beat_i.data_bit;
              raddr   = cur_q;
              state_d = S_DCH;
            end
            OP_CLEAR: begin
              root_valid_d = 1'b0;
              next_free_d  = (NW + 1)'(1);
              cur_d        = '0;
              pend_d       = '0;
              res_valid_o  = 1'b1;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        if (rem_q == '0) begin
          // end of code: mark leaf unless one is already there
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          if (cur_word.leaf) begin
            res_o.status = ST_DUPLICATE;
          end else begin
            wr_word.leaf = 1'b1;
            wr_word.sym  = sym_q;
            mem_we_o     = 1'b1;
          end
        end else if (slot != '0) begin
          // follow existing child
          node_d  = slot;
          fresh_d = 1'b0;
          raddr   = slot;
          rem_d   = rem_q - 1'b1;
        end else if (table_full) begin
          // out of nodes, a node allocated on the way still gets written empty
          res_o.status = ST_FULL;
          res_valid_o  = 1'b1;
          state_d      = S_IDLE;
          mem_we_o     = fresh_q;
        end else begin
          // allocate child and hook it into this node
          if (walk_bit) begin
            wr_word.right = next_free_q[NW-1:0];
          end else begin
            wr_word.left = next_free_q[NW-1:0];
          end
          mem_we_o    = 1'b1;
          node_d      = next_free_q[NW-1:0];
          fresh_d     = 1'b1;
          next_free_d = next_free_q + 1'b1;
          rem_d       = rem_q - 1'b1;
        end
      end

      S_DCH: begin
        if (child == '0) begin
          res_o.status = ST_NO_PATH;
          cur_d        = '0;
          pend_d       = '0;
          res_valid_o  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          child_d = child;
          raddr   = child;
          state_d = S_DLF;
        end
      end

      S_DLF: begin
        res_valid_o = 1'b1;
        state_d     = S_IDLE;
        if (word.leaf) begin
          res_o.symbol_valid = 1'b1;
          res_o.symbol_out   = word.sym;
          cur_d              = '0;
          pend_d             = '0;
        end else begin
          cur_d  = child_q;
          pend_d = (pend_q == PENDING_MAX) ? pend_q : pend_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.pending_bits = pend_d;

    if (mem_we_o && (node_q == '0)) begin
      root_valid_d = 1'b1;
    end
  end

  assign mem_waddr_o = node_q;
  assign mem_wdata_o = NodeW'(wr_word);
  assign mem_raddr_o = raddr;
  assign busy_o      = (state_q != S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_free_q  <= (NW + 1)'(1);
      cur_q        <= '0;
      pend_q       <= '0;
      root_valid_q <= 1'b0;
      rd_addr_q    <= '0;
    end else begin
      state_q      <= state_d;
      next_free_q  <= next_free_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      root_valid_q <= root_valid_d;
      rd_addr_q    <= raddr;
    end
  end

  // walk context
  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    fresh_q <= fresh_d;
    rem_q   <= rem_d;
    bits_q  <= bits_d;
    sym_q   <= sym_d;
    bit_q   <= bit_d;
    child_q <= child_d;
  end

endmodule

>>> rtl/hbsd_checker.sv
module hbsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input hbsd_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hbsd_pkg::out_beat_t out_beat_o
);

  import hbsd_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  // an emitted symbol always comes with ok status and a reset bit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.symbol_valid |->
      out_beat_o.status == ST_OK && out_beat_o.pending_bits == '0)
    else $error("symbol beat with bad status or pending count");

  // a missing path returns to the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status == ST_NO_PATH |->
      out_beat_o.pending_bits == '0 && !out_beat_o.symbol_valid)
    else $error("no-path beat left bits pending");

  // symbol field is zero when no symbol was emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.symbol_valid |-> out_beat_o.symbol_out == '0)
    else $error("symbol field set without a symbol");

  // an insert or decode beat needs table reads, so the input stalls next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
      (in_beat_i.opcode == OP_INSERT || in_beat_i.opcode == OP_DECODE) |=> in_stall_o)
    else $error("input taken while a table walk is running");

endmodule

bind huffman_bit_serial_decoder_core hbsd_checker u_hbsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
